>>> rtl/power_sleep_wake_sequencer_assert.svh
// ----------------------------------------------------------------------------
// Power sleep/wake sequencer assertion macros
// Shared property macros for the sequencer checkers.
// ----------------------------------------------------------------------------
`ifndef POWER_SLEEP_WAKE_SEQUENCER_ASSERT_SVH
`define POWER_SLEEP_WAKE_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define PSWS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("power sequencer check failed");

// next-cycle implication
`define PSWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("power sequencer check failed");

`endif

>>> rtl/psws_pkg.sv
// ----------------------------------------------------------------------------
// psws_pkg
// Types, codes and command tables of the power sleep/wake sequencer.
// ----------------------------------------------------------------------------
package psws_pkg;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;

    localparam logic REG_INIT_ONLINE = 1'b0;
    localparam logic REG_INIT_PHASE  = 1'b1;

    localparam logic [2:0] EVT_SNAPSHOT     = 3'd0;
    localparam logic [2:0] EVT_MANUAL_SLEEP = 3'd1;
    localparam logic [2:0] EVT_LCD_IDLE     = 3'd2;
    localparam logic [2:0] EVT_GPIO_WAKE    = 3'd3;
    localparam logic [2:0] EVT_WAKE_CLASS   = 3'd4;
    localparam logic [2:0] EVT_MAX          = 3'd4;

    localparam logic [2:0] WCLASS_BUTTON2 = 3'd2;
    localparam logic [2:0] WCLASS_MAX     = 3'd4;
    localparam logic [2:0] PHASE_MAX      = 3'd4;
    localparam logic [7:0] ONLINE_MAX     = 8'd1;

    localparam logic [3:0] CMD_STOP_DRAWS  = 4'd0;
    localparam logic [3:0] CMD_WAIT_LCD    = 4'd1;
    localparam logic [3:0] CMD_BL_OFF      = 4'd2;
    localparam logic [3:0] CMD_PANEL_SLEEP = 4'd3;
    localparam logic [3:0] CMD_BLE_STOP    = 4'd4;
    localparam logic [3:0] CMD_ARM_WAKE    = 4'd5;
    localparam logic [3:0] CMD_LOW_POWER   = 4'd6;
    localparam logic [3:0] CMD_ADC         = 4'd7;
    localparam logic [3:0] CMD_EXIT_SLEEP  = 4'd8;
    localparam logic [3:0] CMD_REDRAW      = 4'd9;
    localparam logic [3:0] CMD_BL_ON       = 4'd10;
    localparam logic [3:0] CMD_BLE_START   = 4'd11;

    localparam logic [2:0] RES_NO_CHANGE  = 3'd0;
    localparam logic [2:0] RES_STATUS     = 3'd1;
    localparam logic [2:0] RES_WAIT_LCD   = 3'd2;
    localparam logic [2:0] RES_ASLEEP     = 3'd3;
    localparam logic [2:0] RES_WAIT_CLASS = 3'd4;
    localparam logic [2:0] RES_ACTIVE     = 3'd5;
    localparam logic [2:0] RES_ERROR      = 3'd6;

    typedef enum logic [1:0] {
        MODE_ACTIVE,
        MODE_WAIT_LCD,
        MODE_ASLEEP,
        MODE_WAIT_CLASS
    } psws_mode_t;

    typedef enum logic [2:0] {
        RUN_NONE,
        RUN_SLEEP_START,
        RUN_SLEEP_FINISH,
        RUN_WAKE_ADC,
        RUN_RESUME,
        RUN_BACK_TO_SLEEP
    } psws_run_t;

    typedef struct packed {
        logic             start;
        logic             load;
        logic [IDX_W-1:0] idx;
    } psws_cmd_t;

    typedef struct packed {
        logic last;
    } psws_stat_t;

    function automatic logic [3:0] cmd_of(input psws_run_t run, input logic [IDX_W-1:0] idx);
        logic [3:0] code;
        code = CMD_STOP_DRAWS;
        unique case (run)
            RUN_SLEEP_START:
                code = (idx == 3'd0) ? CMD_STOP_DRAWS : CMD_WAIT_LCD;
            RUN_SLEEP_FINISH:
                unique case (idx)
                    3'd0:    code = CMD_BL_OFF;
                    3'd1:    code = CMD_PANEL_SLEEP;
                    3'd2:    code = CMD_BLE_STOP;
                    3'd3:    code = CMD_ARM_WAKE;
                    default: code = CMD_LOW_POWER;
                endcase
            RUN_WAKE_ADC:
                code = CMD_ADC;
            RUN_RESUME:
                unique case (idx)
                    3'd0:    code = CMD_EXIT_SLEEP;
                    3'd1:    code = CMD_REDRAW;
                    3'd2:    code = CMD_BL_ON;
                    default: code = CMD_BLE_START;
                endcase
            RUN_BACK_TO_SLEEP:
                code = (idx == 3'd0) ? CMD_ARM_WAKE : CMD_LOW_POWER;
            default:
                code = CMD_STOP_DRAWS;
        endcase
        return code;
    endfunction

endpackage

>>> rtl/power_sleep_wake_sequencer.sv
// ----------------------------------------------------------------------------
// power_sleep_wake_sequencer
// Sleep/wake power sequencer: one event in, a run of one to five result
// transactions out, each a power command or a single status answer.
// ----------------------------------------------------------------------------
// Usage:
//   Event channel in_valid/in_ready carries event_kind, wake_class,
//   snap_online and snap_phase. Result channel out_valid/out_ready carries
//   one transaction per power command; last_item marks the end of a run and
//   result_code is valid there. Events that start no run answer with one
//   transaction without a command.
//   APB port: initial_online at 0x0, initial_phase at 0x4; a write also
//   loads the stored snapshot. pready is tied high.
// Timing:
//   An event is accepted and decoded in the idle state, then the run
//   counter gives one result per cycle while the receiver is ready. The
//   state register and then the output register lie between acceptance
//   and the first result. The next event is taken while the last result still
//   sits in the output register.
// Reset: mode active, snapshot and config registers zero, no output.
// Stall: a stalled result holds; the run pauses until it is taken.
// ----------------------------------------------------------------------------
module power_sleep_wake_sequencer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [psws_pkg::ADDR_W-1:0] paddr,
    input  logic [psws_pkg::DATA_W-1:0] pwdata,
    output logic [psws_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  event_kind,
    input  logic [2:0]                  wake_class,
    input  logic [7:0]                  snap_online,
    input  logic [2:0]                  snap_phase,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        has_command,
    output logic [3:0]                  command_code,
    output logic [2:0]                  result_code,
    output logic                        last_item,
    output logic [1:0]                  power_state_view,
    output logic                        online_view,
    output logic [2:0]                  phase_view
);
    import psws_pkg::*;

    psws_cmd_t  cmd;
    psws_stat_t stat;

    assign pready = 1'b1;

    psws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    psws_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .event_kind       (event_kind),
        .wake_class       (wake_class),
        .snap_online      (snap_online),
        .snap_phase       (snap_phase),
        .cmd              (cmd),
        .stat             (stat),
        .has_command      (has_command),
        .command_code     (command_code),
        .result_code      (result_code),
        .last_item        (last_item),
        .power_state_view (power_state_view),
        .online_view      (online_view),
        .phase_view       (phase_view)
    );

endmodule

>>> rtl/psws_datapath.sv
// ----------------------------------------------------------------------------
// psws_datapath
// Power mode, charge snapshot and config registers, event decode and the
// result output register.
// ----------------------------------------------------------------------------
module psws_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [psws_pkg::ADDR_W-1:0] paddr,
    input  logic [psws_pkg::DATA_W-1:0] pwdata,
    output logic [psws_pkg::DATA_W-1:0] prdata,
    input  logic [2:0]                  event_kind,
    input  logic [2:0]                  wake_class,
    input  logic [7:0]                  snap_online,
    input  logic [2:0]                  snap_phase,
    input  psws_pkg::psws_cmd_t         cmd,
    output psws_pkg::psws_stat_t        stat,
    output logic                        has_command,
    output logic [3:0]                  command_code,
    output logic [2:0]                  result_code,
    output logic                        last_item,
    output logic [1:0]                  power_state_view,
    output logic                        online_view,
    output logic [2:0]                  phase_view
);
    import psws_pkg::*;

    logic              init_online_reg;
    logic [2:0]        init_phase_reg;
    psws_mode_t        mode_reg;
    psws_mode_t        mode_next;
    logic              stored_online_reg;
    logic              stored_online_next;
    logic [2:0]        stored_phase_reg;
    logic [2:0]        stored_phase_next;
    psws_run_t         run_reg;
    psws_run_t         run_next;
    logic [IDX_W-1:0]  len_reg;
    logic [IDX_W-1:0]  len_next;
    logic [2:0]        res_reg;
    logic [2:0]        res_next;
    logic              cfg_wr;
    logic              has_command_reg;
    logic [3:0]        command_code_reg;
    logic [2:0]        result_code_reg;
    logic              last_item_reg;
    logic [1:0]        power_state_view_reg;
    logic              online_view_reg;
    logic [2:0]        phase_view_reg;

    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        if (paddr[2] == REG_INIT_ONLINE)
            prdata = {{(DATA_W-1){1'b0}}, init_online_reg};
        else
            prdata = {{(DATA_W-3){1'b0}}, init_phase_reg};
    end

    always_comb
    begin
        run_next           = RUN_NONE;
        len_next           = IDX_W'(1);
        res_next           = RES_NO_CHANGE;
        mode_next          = mode_reg;
        stored_online_next = stored_online_reg;
        stored_phase_next  = stored_phase_reg;
        priority if (event_kind > EVT_MAX)
            res_next = RES_ERROR;
        else if (event_kind == EVT_WAKE_CLASS && wake_class > WCLASS_MAX)
            res_next = RES_ERROR;
        else if (event_kind == EVT_SNAPSHOT)
        begin
            if (snap_online > ONLINE_MAX || snap_phase > PHASE_MAX)
                res_next = RES_ERROR;
            else if (snap_online[0] == stored_online_reg && snap_phase == stored_phase_reg)
                res_next = RES_NO_CHANGE;
            else
            begin
                stored_online_next = snap_online[0];
                stored_phase_next  = snap_phase;
                res_next           = RES_STATUS;
            end
        end
        else
        begin
            unique case (mode_reg)
                MODE_ACTIVE:
                    if (event_kind == EVT_MANUAL_SLEEP)
                    begin
                        run_next  = RUN_SLEEP_START;
                        len_next  = IDX_W'(2);
                        res_next  = RES_WAIT_LCD;
                        mode_next = MODE_WAIT_LCD;
                    end
                MODE_WAIT_LCD:
                    if (event_kind == EVT_LCD_IDLE)
                    begin
                        run_next  = RUN_SLEEP_FINISH;
                        len_next  = IDX_W'(5);
                        res_next  = RES_ASLEEP;
                        mode_next = MODE_ASLEEP;
                    end
                MODE_ASLEEP:
                    if (event_kind == EVT_GPIO_WAKE)
                    begin
                        run_next  = RUN_WAKE_ADC;
                        len_next  = IDX_W'(1);
                        res_next  = RES_WAIT_CLASS;
                        mode_next = MODE_WAIT_CLASS;
                    end
                MODE_WAIT_CLASS:
                    if (event_kind == EVT_WAKE_CLASS)
                    begin
                        if (wake_class == WCLASS_BUTTON2)
                        begin
                            run_next  = RUN_RESUME;
                            len_next  = IDX_W'(4);
                            res_next  = RES_ACTIVE;
                            mode_next = MODE_ACTIVE;
                        end
                        else
                        begin
                            run_next  = RUN_BACK_TO_SLEEP;
                            len_next  = IDX_W'(2);
                            res_next  = RES_ASLEEP;
                            mode_next = MODE_ASLEEP;
                        end
                    end
                default:
                    mode_next = mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_online_reg   <= 1'b0;
            init_phase_reg    <= 3'd0;
            mode_reg          <= MODE_ACTIVE;
            stored_online_reg <= 1'b0;
            stored_phase_reg  <= 3'd0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_INIT_ONLINE)
            begin
                init_online_reg   <= pwdata[0];
                stored_online_reg <= pwdata[0];
            end
            else if (pwdata[2:0] <= PHASE_MAX)
            begin
                init_phase_reg   <= pwdata[2:0];
                stored_phase_reg <= pwdata[2:0];
            end
        end
        else if (cmd.start)
        begin
            mode_reg          <= mode_next;
            stored_online_reg <= stored_online_next;
            stored_phase_reg  <= stored_phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            run_reg <= run_next;
            len_reg <= len_next;
            res_reg <= res_next;
        end
    end

    assign stat.last = (cmd.idx == len_reg - IDX_W'(1));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            has_command_reg      <= (run_reg != RUN_NONE);
            command_code_reg     <= cmd_of(run_reg, cmd.idx);
            result_code_reg      <= stat.last ? res_reg : RES_NO_CHANGE;
            last_item_reg        <= stat.last;
            power_state_view_reg <= mode_reg;
            online_view_reg      <= stored_online_reg;
            phase_view_reg       <= stored_phase_reg;
        end
    end

    assign has_command      = has_command_reg;
    assign command_code     = command_code_reg;
    assign result_code      = result_code_reg;
    assign last_item        = last_item_reg;
    assign power_state_view = power_state_view_reg;
    assign online_view      = online_view_reg;
    assign phase_view       = phase_view_reg;

endmodule

>>> rtl/psws_ctrl.sv
// ----------------------------------------------------------------------------
// psws_ctrl
// Event handshake and command run sequencer: steps the item index and
// drives the output valid register.
// ----------------------------------------------------------------------------
module psws_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output psws_pkg::psws_cmd_t  cmd,
    input  psws_pkg::psws_stat_t stat
);
    import psws_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             start;
    logic             load;

    assign start = in_valid && (state_reg == S_IDLE);
    assign load  = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
                if (start)
                begin
                    state_next = S_EMIT;
                    idx_next   = '0;
                end
            S_EMIT:
                if (load)
                begin
                    out_valid_next = 1'b1;
                    idx_next       = idx_reg + IDX_W'(1);
                    if (stat.last)
                        state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign cmd.start = start;
    assign cmd.load  = load;
    assign cmd.idx   = idx_reg;

endmodule

>>> rtl/psws_checker.sv
// ----------------------------------------------------------------------------
// psws_checker
// Port-level checks of the power sleep/wake sequencer, bound to the top.
// ----------------------------------------------------------------------------
`include "power_sleep_wake_sequencer_assert.svh"

module psws_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       has_command,
    input logic [3:0] command_code,
    input logic [2:0] result_code,
    input logic       last_item
);
    import psws_pkg::*;

    `PSWS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(command_code) && $stable(result_code) && $stable(last_item))
    `PSWS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    `PSWS_ASSERT_NOW(a_single_is_last, clk, rst_n, out_valid && !has_command, last_item && command_code == CMD_STOP_DRAWS)
    `PSWS_ASSERT_NOW(a_result_on_last, clk, rst_n, out_valid && !last_item, result_code == RES_NO_CHANGE)

endmodule

bind power_sleep_wake_sequencer psws_checker u_psws_checker (.*);

>>> tb/tb_power_sleep_wake_sequencer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_power_sleep_wake_sequencer
// Self-checking bench for the sleep/wake power sequencer. Events go in over a
// valid/ready channel while a local model of the power mode and the stored
// charge snapshot predicts every result transaction, which is compared field
// by field as it leaves the block. Directed tests cover snapshots, invalid
// events, every mode transition and the APB registers; random traffic of
// mostly well-formed sleep/wake sequences follows under several settings.
// ----------------------------------------------------------------------------
module tb_power_sleep_wake_sequencer;

    import psws_pkg::*;

    localparam int IDLE_LIMIT = 4000;

    typedef struct packed {
        logic       has_cmd;
        logic [3:0] cmd;
        logic [2:0] res;
        logic       last;
        logic [1:0] mode;
        logic       online;
        logic [2:0] phase;
    } seq_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [2:0]          event_kind = '0;
    logic [2:0]          wake_class = '0;
    logic [7:0]          snap_online = '0;
    logic [2:0]          snap_phase = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                has_command;
    logic [3:0]          command_code;
    logic [2:0]          result_code;
    logic                last_item;
    logic [1:0]          power_state_view;
    logic                online_view;
    logic [2:0]          phase_view;

    psws_mode_t          mode_q = MODE_ACTIVE;
    logic                online_q = 1'b0;
    logic [2:0]          phase_q = '0;
    logic                cfg_online = 1'b0;
    logic [2:0]          cfg_phase = '0;

    seq_result_t         pending_results[$];
    seq_result_t         got_result;
    seq_result_t         want_result;

    logic [2:0]          wake_seq[5] = '{3'd1, 3'd4, 3'd0, 3'd3, 3'd2};

    bit                  no_idle = 1'b0;
    int                  fail_count = 0;
    int                  idle_cycles = 0;
    int                  events_sent = 0;
    int                  results_seen = 0;
    int                  commands_seen = 0;
    int                  resumes_seen = 0;
    int                  errors_seen = 0;

    power_sleep_wake_sequencer dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .event_kind       (event_kind),
        .wake_class       (wake_class),
        .snap_online      (snap_online),
        .snap_phase       (snap_phase),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .has_command      (has_command),
        .command_code     (command_code),
        .result_code      (result_code),
        .last_item        (last_item),
        .power_state_view (power_state_view),
        .online_view      (online_view),
        .phase_view       (phase_view)
    );

    always #1 clk = ~clk;

    function automatic string fmt_result(input seq_result_t r);
        return $sformatf("has=%0d cmd=%0d res=%0d last=%0d mode=%0d online=%0d phase=%0d",
                         r.has_cmd, r.cmd, r.res, r.last, r.mode, r.online, r.phase);
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task automatic push_result(input logic has_cmd, input logic [3:0] cmd,
                               input logic [2:0] res, input logic last);
        seq_result_t r;
        r.has_cmd = has_cmd;
        r.cmd     = cmd;
        r.res     = last ? res : RES_NO_CHANGE;
        r.last    = last;
        r.mode    = mode_q;
        r.online  = online_q;
        r.phase   = phase_q;
        pending_results.push_back(r);
    endtask

    task automatic push_answer(input logic [2:0] res);
        push_result(1'b0, CMD_STOP_DRAWS, res, 1'b1);
    endtask

    task automatic predict_event(input logic [2:0] kind, input logic [2:0] wc,
                                 input logic [7:0] on, input logic [2:0] ph);
        if (kind > EVT_MAX)
            push_answer(RES_ERROR);
        else if (kind == EVT_WAKE_CLASS && wc > WCLASS_MAX)
            push_answer(RES_ERROR);
        else if (kind == EVT_SNAPSHOT)
        begin
            if (on > ONLINE_MAX || ph > PHASE_MAX)
                push_answer(RES_ERROR);
            else if (on[0] == online_q && ph == phase_q)
                push_answer(RES_NO_CHANGE);
            else
            begin
                online_q = on[0];
                phase_q  = ph;
                push_answer(RES_STATUS);
            end
        end
        else if (mode_q == MODE_ACTIVE && kind == EVT_MANUAL_SLEEP)
        begin
            mode_q = MODE_WAIT_LCD;
            push_result(1'b1, CMD_STOP_DRAWS, RES_WAIT_LCD, 1'b0);
            push_result(1'b1, CMD_WAIT_LCD, RES_WAIT_LCD, 1'b1);
        end
        else if (mode_q == MODE_WAIT_LCD && kind == EVT_LCD_IDLE)
        begin
            mode_q = MODE_ASLEEP;
            push_result(1'b1, CMD_BL_OFF, RES_ASLEEP, 1'b0);
            push_result(1'b1, CMD_PANEL_SLEEP, RES_ASLEEP, 1'b0);
            push_result(1'b1, CMD_BLE_STOP, RES_ASLEEP, 1'b0);
            push_result(1'b1, CMD_ARM_WAKE, RES_ASLEEP, 1'b0);
            push_result(1'b1, CMD_LOW_POWER, RES_ASLEEP, 1'b1);
        end
        else if (mode_q == MODE_ASLEEP && kind == EVT_GPIO_WAKE)
        begin
            mode_q = MODE_WAIT_CLASS;
            push_result(1'b1, CMD_ADC, RES_WAIT_CLASS, 1'b1);
        end
        else if (mode_q == MODE_WAIT_CLASS && kind == EVT_WAKE_CLASS && wc == WCLASS_BUTTON2)
        begin
            mode_q = MODE_ACTIVE;
            push_result(1'b1, CMD_EXIT_SLEEP, RES_ACTIVE, 1'b0);
            push_result(1'b1, CMD_REDRAW, RES_ACTIVE, 1'b0);
            push_result(1'b1, CMD_BL_ON, RES_ACTIVE, 1'b0);
            push_result(1'b1, CMD_BLE_START, RES_ACTIVE, 1'b1);
        end
        else if (mode_q == MODE_WAIT_CLASS && kind == EVT_WAKE_CLASS)
        begin
            mode_q = MODE_ASLEEP;
            push_result(1'b1, CMD_ARM_WAKE, RES_ASLEEP, 1'b0);
            push_result(1'b1, CMD_LOW_POWER, RES_ASLEEP, 1'b1);
        end
        else
            push_answer(RES_NO_CHANGE);
    endtask

    task automatic write_register(input logic idx, input logic [DATA_W-1:0] value);
        if (idx == REG_INIT_ONLINE)
        begin
            cfg_online = value[0];
            online_q   = value[0];
        end
        else if (value[2:0] <= PHASE_MAX)
        begin
            cfg_phase = value[2:0];
            phase_q   = value[2:0];
        end
    endtask

    task automatic apb_write(input logic idx, input logic [DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        write_register(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read_check(input logic idx);
        logic [DATA_W-1:0] want;
        want = (idx == REG_INIT_ONLINE) ? DATA_W'(cfg_online) : DATA_W'(cfg_phase);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want)
            note_failure($sformatf("register %0d read: expected 0x%0h got 0x%0h",
                                   idx, want, prdata));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_event(input logic [2:0] kind, input logic [2:0] wc,
                              input logic [7:0] on, input logic [2:0] ph);
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        event_kind  <= kind;
        wake_class  <= wc;
        snap_online <= on;
        snap_phase  <= ph;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_event(kind, wc, on, ph);
        events_sent++;
    endtask

    // sender holds off until the block has delivered every predicted result
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic send_filler(input logic [2:0] kind);
        send_event(kind, 3'($urandom), 8'($urandom), 3'($urandom));
    endtask

    task automatic test_reset_values();
        apb_read_check(REG_INIT_ONLINE);
        apb_read_check(REG_INIT_PHASE);
        send_event(EVT_SNAPSHOT, 3'($urandom), 8'd0, 3'd0);
        wait_drained();
    endtask

    task automatic test_config_registers();
        apb_write(REG_INIT_ONLINE, {$urandom} | 32'h1);
        apb_write(REG_INIT_PHASE, {$urandom} & 32'hFFFF_FFF8 | 32'(PHASE_MAX));
        apb_read_check(REG_INIT_ONLINE);
        apb_read_check(REG_INIT_PHASE);
        for (int p = 5; p <= 7; p++)
            apb_write(REG_INIT_PHASE, {$urandom} & 32'hFFFF_FFF8 | 32'(p));
        apb_read_check(REG_INIT_PHASE);
        send_event(EVT_SNAPSHOT, 3'($urandom), 8'd1, PHASE_MAX);
        wait_drained();
        apb_write(REG_INIT_ONLINE, {$urandom} & 32'hFFFF_FFFE);
        apb_write(REG_INIT_PHASE, {$urandom} & 32'hFFFF_FFF8);
        apb_read_check(REG_INIT_ONLINE);
        apb_read_check(REG_INIT_PHASE);
    endtask

    task automatic test_snapshots();
        send_event(EVT_SNAPSHOT, 3'd7, 8'd2, 3'd0);
        send_event(EVT_SNAPSHOT, 3'd0, 8'd255, 3'd3);
        send_event(EVT_SNAPSHOT, 3'd5, 8'd0, 3'd5);
        send_event(EVT_SNAPSHOT, 3'd2, 8'd1, 3'd7);
        send_event(EVT_SNAPSHOT, 3'd6, 8'd1, 3'd3);
        send_event(EVT_SNAPSHOT, 3'd1, 8'd1, 3'd3);
    endtask

    task automatic test_invalid_events();
        for (int k = EVT_MAX + 1; k <= 7; k++)
            send_filler(3'(k));
    endtask

    task automatic test_sleep_wake_cycle();
        send_event(EVT_WAKE_CLASS, 3'd5, 8'($urandom), 3'($urandom));
        send_filler(EVT_MANUAL_SLEEP);
        send_filler(EVT_MANUAL_SLEEP);
        send_event(EVT_WAKE_CLASS, 3'd7, 8'($urandom), 3'($urandom));
        send_filler(EVT_LCD_IDLE);
        send_event(EVT_WAKE_CLASS, 3'd6, 8'($urandom), 3'($urandom));
        send_filler(EVT_GPIO_WAKE);
        send_filler(EVT_GPIO_WAKE);
        foreach (wake_seq[i])
        begin
            send_event(EVT_WAKE_CLASS, wake_seq[i], 8'($urandom), 3'($urandom));
            if (wake_seq[i] != WCLASS_BUTTON2)
                send_filler(EVT_GPIO_WAKE);
        end
        wait_drained();
    endtask

    task automatic test_random_traffic(input int count, input bit calm);
        logic [2:0] kind;
        logic [2:0] wc;
        logic [7:0] on;
        logic [2:0] ph;
        no_idle = calm;
        for (int i = 0; i < count; i++)
        begin
            wc = 3'($urandom);
            on = 8'($urandom);
            ph = 3'($urandom);
            if ($urandom_range(99) < 70)
            begin
                case (mode_q)
                    MODE_ACTIVE:     kind = EVT_MANUAL_SLEEP;
                    MODE_WAIT_LCD:   kind = EVT_LCD_IDLE;
                    MODE_ASLEEP:     kind = EVT_GPIO_WAKE;
                    default:
                    begin
                        kind = EVT_WAKE_CLASS;
                        wc   = ($urandom_range(99) < 40) ? WCLASS_BUTTON2
                                                         : 3'($urandom_range(WCLASS_MAX));
                    end
                endcase
                if ($urandom_range(99) < 15)
                begin
                    kind = EVT_SNAPSHOT;
                    on   = 8'($urandom_range(1));
                    ph   = 3'($urandom_range(PHASE_MAX));
                end
            end
            else
            begin
                kind = 3'($urandom);
                if ($urandom_range(1))
                    on = 8'($urandom_range(1));
            end
            send_event(kind, wc, on, ph);
            if ($urandom_range(39) == 0)
                wait_drained();
        end
        wait_drained();
        no_idle = 1'b0;
    endtask

    always @(negedge clk)
        out_ready <= no_idle || ($urandom_range(99) >= 20);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got_result = {has_command, command_code, result_code, last_item,
                          power_state_view, online_view, phase_view};
            results_seen++;
            if (has_command)
                commands_seen++;
            if (last_item && result_code == RES_ACTIVE)
                resumes_seen++;
            if (last_item && result_code == RES_ERROR)
                errors_seen++;
            if (pending_results.size() == 0)
                note_failure($sformatf("unexpected transaction: %s", fmt_result(got_result)));
            else
            begin
                want_result = pending_results.pop_front();
                if (got_result !== want_result)
                    note_failure($sformatf("expected %s, got %s",
                                           fmt_result(want_result), fmt_result(got_result)));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                         IDLE_LIMIT, pending_results.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_config_registers();
        test_snapshots();
        test_invalid_events();
        test_sleep_wake_cycle();

        test_random_traffic(45, 1'b0);
        apb_write(REG_INIT_ONLINE, {$urandom} | 32'h1);
        apb_write(REG_INIT_PHASE, {$urandom} & 32'hFFFF_FFF8 | 32'(PHASE_MAX));
        test_random_traffic(45, 1'b0);
        apb_write(REG_INIT_PHASE, {$urandom} & 32'hFFFF_FFF8 | 32'd2);
        test_random_traffic(45, 1'b1);
        apb_write(REG_INIT_ONLINE, {$urandom} & 32'hFFFF_FFFE);
        apb_write(REG_INIT_PHASE, {$urandom} & 32'hFFFF_FFF8 | 32'(PHASE_MAX));
        apb_read_check(REG_INIT_ONLINE);
        apb_read_check(REG_INIT_PHASE);
        test_random_traffic(45, 1'b0);

        wait_drained();
        repeat (20) @(posedge clk);
        if (pending_results.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_results.size()));

        $display("Ran %0d events through all four power modes; checked %0d results,",
                 events_sent, results_seen);
        $display("%0d of them commands, %0d resumes, %0d error answers, %0d mismatches",
                 commands_seen, resumes_seen, errors_seen, fail_count);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/psws_pkg.sv
rtl/psws_datapath.sv
rtl/psws_ctrl.sv
rtl/power_sleep_wake_sequencer.sv
rtl/psws_checker.sv
tb/tb_power_sleep_wake_sequencer.sv
